>>> hdl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define WPM_NEVER(lbl, expr, msg) \
  `WPM_ASSERT(lbl, !(expr), msg)

`endif

>>> hdl/wpm_pkg.sv
// Shared constants and types of the wildcard pattern matcher.
package wpm_pkg;

  localparam int unsigned MaxPattern = 32;

  localparam logic [7:0] SymStar = 8'd42;
  localparam logic [7:0] SymAny  = 8'd63;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActText   = 2'd2,
    ActQuery  = 2'd3
  } action_e;

  // Decoded command for the item being committed this cycle.
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic query;
  } cmd_t;

endpackage

>>> hdl/wpm_pattern.sv
// Pattern store, length, overflow flag and empty-text vector.
module wpm_pattern #(
  parameter int unsigned MAX_PATTERN = 32,
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpm_pkg::cmd_t                 cmd_i,
  input  logic [7:0]                    sym_i,
  output logic [MAX_PATTERN-1:0][7:0]   pat_sym_o,
  output logic [MAX_PATTERN-1:0]        pat_act_o,
  output logic [MAX_PATTERN:0]          empty_vec_o,
  output logic [LenW-1:0]               len_o,
  output logic                          ovf_o
);
  import wpm_pkg::*;

  logic [MAX_PATTERN-1:0][7:0] sym_q;
  logic [LenW-1:0]             len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic [MAX_PATTERN:0]        empty_q, empty_d;

  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    empty_d = empty_q;
    if (cmd_i.clear) begin
      len_d   = '0;
      ovf_d   = 1'b0;
      empty_d = {{MAX_PATTERN{1'b0}}, 1'b1};
    end else if (cmd_i.append) begin
      if (len_q == LenW'(MAX_PATTERN)) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LenW'(1);
        // Extend the empty-text vector through one more leading star.
        for (int k = 0; k < MAX_PATTERN; k++) begin
          if (len_q == LenW'(k)) begin
            empty_d[k+1] = empty_q[k] & (sym_i == SymStar);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      empty_q <= {{MAX_PATTERN{1'b0}}, 1'b1};
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (cmd_i.append && (len_q == LenW'(k))) begin
        sym_q[k] <= sym_i;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_act_o[k] = (len_q > LenW'(k));
    end
  end

  assign pat_sym_o   = sym_q;
  assign empty_vec_o = empty_q;
  assign len_o       = len_q;
  assign ovf_o       = ovf_q;

endmodule

>>> hdl/wpm_match.sv
// Bit-parallel match vector with a log-depth prefix across star runs.
module wpm_match #(
  parameter int unsigned MAX_PATTERN = 32,
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpm_pkg::cmd_t                 cmd_i,
  input  logic [7:0]                    sym_i,
  input  logic                          last_i,
  input  logic [MAX_PATTERN-1:0][7:0]   pat_sym_i,
  input  logic [MAX_PATTERN-1:0]        pat_act_i,
  input  logic [MAX_PATTERN:0]          empty_vec_i,
  input  logic [LenW-1:0]               len_i,
  output logic                          matched_o
);
  import wpm_pkg::*;

  localparam int unsigned Levels = LenW;

  logic [MAX_PATTERN:0]             mv_q;
  logic                             start_q;
  logic [MAX_PATTERN:0]             base;
  logic [Levels:0][MAX_PATTERN:0]   gen;
  logic [Levels:0][MAX_PATTERN:0]   prop;
  logic [MAX_PATTERN:0]             next;

  always_comb begin
    logic is_star;
    logic is_ok;
    base       = start_q ? empty_vec_i : mv_q;
    gen        = '0;
    prop       = '0;
    // Per position: a star passes on the bit from its left, a literal
    // or '?' takes the previous prefix bit when the byte fits.
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      is_star     = (pat_sym_i[k-1] == SymStar);
      is_ok       = (pat_sym_i[k-1] == SymAny) || (pat_sym_i[k-1] == sym_i);
      gen[0][k]   = pat_act_i[k-1] & (is_star ? base[k] : (is_ok & base[k-1]));
      prop[0][k]  = pat_act_i[k-1] & is_star;
    end
    for (int lv = 0; lv < Levels; lv++) begin
      for (int k = 0; k <= MAX_PATTERN; k++) begin
        if (k >= (1 << lv)) begin
          gen[lv+1][k]  = gen[lv][k] | (prop[lv][k] & gen[lv][k - (1 << lv)]);
          prop[lv+1][k] = prop[lv][k] & prop[lv][k - (1 << lv)];
        end else begin
          gen[lv+1][k]  = gen[lv][k];
          prop[lv+1][k] = prop[lv][k];
        end
      end
    end
    next      = gen[Levels];
    matched_o = cmd_i.text ? next[len_i] : empty_vec_i[len_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q    <= {{MAX_PATTERN{1'b0}}, 1'b1};
      start_q <= 1'b1;
    end else if (cmd_i.text) begin
      mv_q    <= next;
      start_q <= last_i;
    end else if (cmd_i.clear || cmd_i.append) begin
      start_q <= 1'b1;
    end
  end

endmodule

>>> hdl/wildcard_pattern_matcher_top.sv
// Top level of the wildcard pattern matcher: stream ports and pipeline.
// The block holds a pattern of up to MAX_PATTERN bytes, where '*' matches any
// run of bytes (also none), '?' matches any one byte and every other byte only
// itself. The tuser of an item selects clear pattern, append pattern byte,
// text byte or empty-text query; clear and append give no result, a text byte
// gives one result saying whether the text so far matches the whole pattern,
// and a query says whether the empty text matches. tlast on a text byte ends
// the string, and the next text byte starts a new one; appending also restarts
// a string in progress. Bytes appended beyond capacity are dropped and set a
// sticky overflow flag, cleared only by a clear item or reset. One item is
// taken every cycle while results drain: an item waits in the input register
// until the result register is free or being drained, then is committed, where
// one match vector bit per pattern prefix is updated in parallel (a log-depth
// prefix carries matches across runs of stars) and the result lands in the
// output register. The input register takes a new item while a result waits,
// so a stall on the result side holds two items before the input side stops.
`include "assert_macros.svh"

module wildcard_pattern_matcher_top #(
  parameter int unsigned MAX_PATTERN = wpm_pkg::MaxPattern
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] action
  input  logic       s_axis_tlast,   // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
  output logic       m_axis_tlast    // string_done
);
  import wpm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  // Input register.
  logic       s1_valid_q;
  action_e    s1_act_q;
  logic [7:0] s1_sym_q;
  logic       s1_last_q;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic out_matched_q;
  logic out_ovf_q;
  logic out_last_q;

  logic advance;
  cmd_t cmd;
  logic emit;

  logic [MAX_PATTERN-1:0][7:0] pat_sym;
  logic [MAX_PATTERN-1:0]      pat_act;
  logic [MAX_PATTERN:0]        empty_vec;
  logic [LenW-1:0]             pat_len;
  logic                        pat_ovf;
  logic                        matched;

  // Commit the held item when the result register is free or being drained.
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  always_comb begin
    cmd = '0;
    if (advance) begin
      case (s1_act_q)
        ActClear:  cmd.clear  = 1'b1;
        ActAppend: cmd.append = 1'b1;
        ActText:   cmd.text   = 1'b1;
        ActQuery:  cmd.query  = 1'b1;
        default:   cmd        = '0;
      endcase
    end
  end

  assign emit = cmd.text || cmd.query;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Load the input register on every accepted item.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_act_q  <= action_e'(s_axis_tuser);
      s1_sym_q  <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  wpm_pattern #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sym_i       (s1_sym_q),
    .pat_sym_o   (pat_sym),
    .pat_act_o   (pat_act),
    .empty_vec_o (empty_vec),
    .len_o       (pat_len),
    .ovf_o       (pat_ovf)
  );

  wpm_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sym_i       (s1_sym_q),
    .last_i      (s1_last_q),
    .pat_sym_i   (pat_sym),
    .pat_act_i   (pat_act),
    .empty_vec_i (empty_vec),
    .len_i       (pat_len),
    .matched_o   (matched)
  );

  // Hold a result until taken; a new one only lands in a free slot.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_matched_q <= matched;
      out_ovf_q     <= pat_ovf;
      out_last_q    <= cmd.query || s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_matched_q};
  assign m_axis_tlast  = out_last_q;

  // Length never runs past capacity.
  `WPM_NEVER(a_len_cap, pat_len > LenW'(MAX_PATTERN), "pattern length beyond capacity")
  // Overflow is only ever raised with a full pattern.
  `WPM_ASSERT(a_ovf_full, pat_ovf |-> (pat_len == LenW'(MAX_PATTERN)), "overflow without full pattern")
  // The empty pattern matches the empty text.
  `WPM_ASSERT(a_empty_query, (cmd.query && (pat_len == '0)) |=> m_axis_tdata[0], "empty query missed")
  // The empty pattern never matches a text byte.
  `WPM_ASSERT(a_empty_text, (cmd.text && (pat_len == '0)) |=> !m_axis_tdata[0], "text matched empty pattern")

endmodule
